[hw/rtl/van_genuchten_rel_permeability_macros.svh]
// Assertion macros shared by the relative permeability block.
`ifndef VAN_GENUCHTEN_REL_PERMEABILITY_MACROS_SVH
`define VAN_GENUCHTEN_REL_PERMEABILITY_MACROS_SVH

// Property that must hold at every edge outside reset.
`define VGRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define VGRP_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) else $error(msg);

`endif

[hw/rtl/vgrp_pkg.sv]
// Shared constants, command types and constant tables of the relative permeability block.
package vgrp_pkg;

  localparam int FRAC  = 16;              // fraction bits of the fixed point values outside exp2
  localparam int FX_W  = FRAC + 1;        // saturation / permeability width
  localparam int N_W   = FRAC + 5;        // shape exponent width, config data width
  localparam int DIV_W = 2 * FRAC + 1;    // dividend / quotient width
  localparam int K_W   = $clog2(FRAC + 1);
  localparam int MAG_W = FRAC + K_W;      // |log2 x| width
  localparam int PR_W  = DIV_W + MAG_W;   // exponent times log product
  localparam int IP_W  = $clog2(FRAC + 2);
  localparam int P_W   = FRAC + IP_W;     // scaled exponent width
  localparam int EXP_W = 32;              // internal fraction bits of exp2
  localparam int R_W   = EXP_W + 1;
  localparam int SQ_W  = 2 * FRAC + 2;    // square root radicand width
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int BIT_W = $clog2(FRAC);
  localparam int IDX_W = 3;
  localparam int SEL_W = 3;

  localparam logic [FX_W-1:0] ONE     = {1'b1, {FRAC{1'b0}}};
  localparam logic [PR_W-1:0] LIM     = PR_W'(FRAC + 1) << (2 * FRAC);
  localparam logic [N_W-1:0]  N_RESET = N_W'(2) << FRAC;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SA_MIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SB_MIN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHAPE_N  = 3'd2;
  localparam logic [IDX_W-1:0] REG_KRA_PEAK = 3'd3;
  localparam logic [IDX_W-1:0] REG_KRB_PEAK = 3'd4;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_SAVE,
    OP_LOG_INIT, OP_LOG_NORM, OP_LOG_SQ, OP_LOG_SAVE,
    OP_EXP_INIT, OP_EXP_STEP, OP_EXP_SAVE,
    OP_SQRT_INIT, OP_SQRT_STEP, OP_SQRT_SAVE, OP_MUL, OP_OUT
  } op_e;

  // divider operand sets
  localparam logic [SEL_W-1:0] DIV_SE   = 3'd0;
  localparam logic [SEL_W-1:0] DIV_M    = 3'd1;
  localparam logic [SEL_W-1:0] DIV_INVM = 3'd2;
  // log sources
  localparam logic [SEL_W-1:0] LOG_SE   = 3'd0;
  localparam logic [SEL_W-1:0] LOG_U    = 3'd1;
  // exponents
  localparam logic [SEL_W-1:0] EXA_INVM = 3'd0;
  localparam logic [SEL_W-1:0] EXA_M2   = 3'd1;
  localparam logic [SEL_W-1:0] EXA_M    = 3'd2;
  // power destinations
  localparam logic [SEL_W-1:0] DST_T    = 3'd0;
  localparam logic [SEL_W-1:0] DST_A2   = 3'd1;
  localparam logic [SEL_W-1:0] DST_V    = 3'd2;
  // square root operands
  localparam logic [SEL_W-1:0] SQ_A     = 3'd0;
  localparam logic [SEL_W-1:0] SQ_B     = 3'd1;
  // final products
  localparam logic [SEL_W-1:0] MUL_KA1  = 3'd0;
  localparam logic [SEL_W-1:0] MUL_KA2  = 3'd1;
  localparam logic [SEL_W-1:0] MUL_W    = 3'd2;
  localparam logic [SEL_W-1:0] MUL_KB1  = 3'd3;
  localparam logic [SEL_W-1:0] MUL_KB2  = 3'd4;

  typedef struct packed {
    op_e              op;
    logic [SEL_W-1:0] sel;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic norm_done;
  } sts_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bm;
    rem = v;
    res = '0;
    bm  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bm) begin
        rem = rem - (res + bm);
        res = (res >> 1) + bm;
      end else begin
        res = res >> 1;
      end
      bm = bm >> 2;
    end
    return res;
  endfunction

  typedef logic [EXP_W-1:0] exp_tab_t [FRAC];

  // 2^(-2^-(i+1)) with EXP_W fraction bits, each from the previous by square root
  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [63:0] c;
    c = isqrt_c(64'h8000_0000_0000_0000);
    for (int i = 0; i < FRAC; i++) begin
      tab[i] = c[EXP_W-1:0];
      c      = isqrt_c(c << EXP_W);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_C = exp_table();

endpackage

[hw/rtl/vgrp_dpath.sv]
// Datapath: config registers, shared divider, log2, exp2, square root and multiplier.
module vgrp_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vgrp_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [vgrp_pkg::N_W-1:0]     cfg_data_i,
  input  logic [vgrp_pkg::FX_W-1:0]    sat_b_i,
  input  vgrp_pkg::cmd_t               cmd_i,
  output vgrp_pkg::sts_t               sts_o,
  output logic [vgrp_pkg::FX_W-1:0]    perm_a_o,
  output logic [vgrp_pkg::FX_W-1:0]    perm_b_o,
  output logic                         bad_config_o
);

  localparam int F       = vgrp_pkg::FRAC;
  localparam int BIT_LEN = vgrp_pkg::BIT_W;

  // config registers
  logic [vgrp_pkg::FX_W-1:0] sa_min_q, sb_min_q, kra_q, krb_q;
  logic [vgrp_pkg::N_W-1:0]  shape_n_q;

  // item registers
  logic [vgrp_pkg::FX_W-1:0]  sb_q, se_q, m_q, u_q, a2_q, w_q, a1_q, b1_q, acc_q, ka_q, kb_q;
  logic [vgrp_pkg::DIV_W-1:0] invm_q;
  logic                       bad_q;
  // divider
  logic [vgrp_pkg::DIV_W-1:0] quo_q;
  logic [vgrp_pkg::N_W-1:0]   rem_q, dvs_q;
  // log2
  logic [vgrp_pkg::FX_W-1:0]  y_q;
  logic [vgrp_pkg::K_W-1:0]   k_q;
  logic [F-1:0]               frac_q;
  logic [vgrp_pkg::MAG_W-1:0] mag_q;
  logic                       pw_zero_q, pw_one_q;
  // exp2
  logic [vgrp_pkg::P_W-1:0]   p_q;
  logic [vgrp_pkg::R_W-1:0]   r_q;
  logic                       pz_q;
  // square root
  logic [vgrp_pkg::SQ_W-1:0]  sqv_q;
  logic [F+2:0]               sqr_q;
  logic [vgrp_pkg::FX_W-1:0]  root_q;
  // outputs
  logic [vgrp_pkg::FX_W-1:0]  perm_a_q, perm_b_q;
  logic                       bad_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_min_q  <= '0;
      sb_min_q  <= '0;
      shape_n_q <= vgrp_pkg::N_RESET;
      kra_q     <= vgrp_pkg::ONE;
      krb_q     <= vgrp_pkg::ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vgrp_pkg::REG_SA_MIN:   sa_min_q  <= cfg_data_i[vgrp_pkg::FX_W-1:0];
        vgrp_pkg::REG_SB_MIN:   sb_min_q  <= cfg_data_i[vgrp_pkg::FX_W-1:0];
        vgrp_pkg::REG_SHAPE_N:  shape_n_q <= cfg_data_i;
        vgrp_pkg::REG_KRA_PEAK: kra_q     <= cfg_data_i[vgrp_pkg::FX_W-1:0];
        vgrp_pkg::REG_KRB_PEAK: krb_q     <= cfg_data_i[vgrp_pkg::FX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- combinational helpers ----
  logic [F+1:0]               res_sum;
  logic [F+1:0]               den;
  logic [vgrp_pkg::FX_W-1:0]  diff;
  logic [vgrp_pkg::N_W-1:0]   n_eff;
  logic [vgrp_pkg::N_W:0]     dtrial;
  logic                       dge;
  logic [vgrp_pkg::FX_W-1:0]  log_x;
  logic [vgrp_pkg::FX_W-1:0]  mul_a, mul_b, msat;
  logic [2*F+1:0]             mprod;
  logic [F+1:0]               msh;
  logic [vgrp_pkg::DIV_W-1:0] ea;
  logic [vgrp_pkg::PR_W-1:0]  eprod;
  logic [BIT_LEN-1:0]         bidx;
  logic [vgrp_pkg::R_W+vgrp_pkg::EXP_W-1:0] rprod;
  logic [vgrp_pkg::R_W-1:0]   eshift;
  logic [vgrp_pkg::FX_W-1:0]  pval;
  logic [F+4:0]               srem2;
  logic [F+2:0]               strial;
  logic                       sge;
  logic [vgrp_pkg::FX_W-1:0]  sq_x;

  always_comb begin
    res_sum = (F+2)'(sa_min_q) + (F+2)'(sb_min_q);
    den     = (F+2)'(vgrp_pkg::ONE) - res_sum;
    diff    = (sb_q > sb_min_q) ? (sb_q - sb_min_q) : '0;
    n_eff   = (shape_n_q < (vgrp_pkg::N_W'(vgrp_pkg::ONE) + 1'b1))
              ? (vgrp_pkg::N_W'(vgrp_pkg::ONE) + 1'b1) : shape_n_q;

    dtrial = {rem_q, quo_q[vgrp_pkg::DIV_W-1]};
    dge    = dtrial >= {1'b0, dvs_q};

    log_x = (cmd_i.sel == vgrp_pkg::LOG_U) ? u_q : se_q;

    // shared narrow multiplier
    mul_a = y_q;
    mul_b = y_q;
    if (cmd_i.op == vgrp_pkg::OP_MUL) begin
      case (cmd_i.sel)
        vgrp_pkg::MUL_KA1: begin mul_a = kra_q; mul_b = a1_q; end
        vgrp_pkg::MUL_KA2: begin mul_a = acc_q; mul_b = a2_q; end
        vgrp_pkg::MUL_W:   begin mul_a = w_q;   mul_b = w_q;  end
        vgrp_pkg::MUL_KB1: begin mul_a = krb_q; mul_b = b1_q; end
        vgrp_pkg::MUL_KB2: begin mul_a = acc_q; mul_b = b1_q; end
        default: ;
      endcase
    end
    mprod = (2*F+2)'(mul_a) * (2*F+2)'(mul_b);
    msh   = mprod[2*F+1:F];
    msat  = (msh > (F+2)'(vgrp_pkg::ONE)) ? vgrp_pkg::ONE : msh[F:0];

    case (cmd_i.sel)
      vgrp_pkg::EXA_M2: ea = vgrp_pkg::DIV_W'({m_q, 1'b0});
      vgrp_pkg::EXA_M:  ea = vgrp_pkg::DIV_W'(m_q);
      default:          ea = invm_q;
    endcase
    eprod = vgrp_pkg::PR_W'(ea) * vgrp_pkg::PR_W'(mag_q);

    bidx  = BIT_LEN'(F - 1 - int'(cmd_i.idx));
    rprod = (vgrp_pkg::R_W + vgrp_pkg::EXP_W)'(r_q)
            * (vgrp_pkg::R_W + vgrp_pkg::EXP_W)'(vgrp_pkg::EXP_C[cmd_i.idx[BIT_LEN-1:0]]);

    eshift = (r_q >> (vgrp_pkg::EXP_W - F)) >> p_q[vgrp_pkg::P_W-1:F];
    if (pw_zero_q) begin
      pval = '0;
    end else if (pw_one_q) begin
      pval = vgrp_pkg::ONE;
    end else if (pz_q) begin
      pval = '0;
    end else begin
      pval = (eshift > vgrp_pkg::R_W'(vgrp_pkg::ONE)) ? vgrp_pkg::ONE
             : eshift[vgrp_pkg::FX_W-1:0];
    end

    srem2  = {sqr_q, sqv_q[vgrp_pkg::SQ_W-1 -: 2]};
    strial = {root_q, 2'b01};
    sge    = srem2 >= (F+5)'(strial);
    sq_x   = (cmd_i.sel == vgrp_pkg::SQ_B) ? se_q : (vgrp_pkg::ONE - se_q);
  end

  assign sts_o.bad       = res_sum >= (F+2)'(vgrp_pkg::ONE);
  assign sts_o.norm_done = y_q[F] | pw_zero_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vgrp_pkg::OP_LOAD: begin
        sb_q  <= sat_b_i;
        bad_q <= sts_o.bad;
      end
      vgrp_pkg::OP_DIV_INIT: begin
        rem_q <= '0;
        case (cmd_i.sel)
          vgrp_pkg::DIV_SE: begin
            quo_q <= {diff, {F{1'b0}}};
            dvs_q <= vgrp_pkg::N_W'(den);
          end
          vgrp_pkg::DIV_M: begin
            quo_q <= vgrp_pkg::DIV_W'(1) << (2*F);
            dvs_q <= n_eff;
          end
          default: begin
            quo_q <= vgrp_pkg::DIV_W'(1) << (2*F);
            dvs_q <= vgrp_pkg::N_W'(m_q);
          end
        endcase
      end
      vgrp_pkg::OP_DIV_STEP: begin
        rem_q <= dge ? vgrp_pkg::N_W'(dtrial - {1'b0, dvs_q}) : dtrial[vgrp_pkg::N_W-1:0];
        quo_q <= {quo_q[vgrp_pkg::DIV_W-2:0], dge};
      end
      vgrp_pkg::OP_DIV_SAVE: begin
        case (cmd_i.sel)
          vgrp_pkg::DIV_SE:
            se_q <= (quo_q > vgrp_pkg::DIV_W'(vgrp_pkg::ONE)) ? vgrp_pkg::ONE
                    : quo_q[vgrp_pkg::FX_W-1:0];
          vgrp_pkg::DIV_M: m_q <= vgrp_pkg::ONE - quo_q[vgrp_pkg::FX_W-1:0];
          default:         invm_q <= quo_q;
        endcase
      end
      vgrp_pkg::OP_LOG_INIT: begin
        y_q       <= log_x;
        k_q       <= '0;
        frac_q    <= '0;
        pw_zero_q <= (log_x == '0);
        pw_one_q  <= log_x[F];
      end
      vgrp_pkg::OP_LOG_NORM: begin
        y_q <= {y_q[F-1:0], 1'b0};
        k_q <= k_q + 1'b1;
      end
      vgrp_pkg::OP_LOG_SQ: begin
        frac_q <= {frac_q[F-2:0], msh[F+1]};
        y_q    <= msh[F+1] ? msh[F+1:1] : msh[F:0];
      end
      vgrp_pkg::OP_LOG_SAVE: mag_q <= {k_q, {F{1'b0}}} - vgrp_pkg::MAG_W'(frac_q);
      vgrp_pkg::OP_EXP_INIT: begin
        pz_q <= eprod > vgrp_pkg::LIM;
        p_q  <= eprod[F +: vgrp_pkg::P_W];
        r_q  <= vgrp_pkg::R_W'(1) << vgrp_pkg::EXP_W;
      end
      vgrp_pkg::OP_EXP_STEP: begin
        if (p_q[bidx]) r_q <= rprod[vgrp_pkg::EXP_W +: vgrp_pkg::R_W];
      end
      vgrp_pkg::OP_EXP_SAVE: begin
        case (cmd_i.sel)
          vgrp_pkg::DST_T:  u_q  <= vgrp_pkg::ONE - pval;
          vgrp_pkg::DST_A2: a2_q <= pval;
          default:          w_q  <= vgrp_pkg::ONE - pval;
        endcase
      end
      vgrp_pkg::OP_SQRT_INIT: begin
        sqv_q  <= {1'b0, sq_x, {F{1'b0}}};
        sqr_q  <= '0;
        root_q <= '0;
      end
      vgrp_pkg::OP_SQRT_STEP: begin
        sqv_q  <= {sqv_q[vgrp_pkg::SQ_W-3:0], 2'b00};
        sqr_q  <= sge ? (F+3)'(srem2 - (F+5)'(strial)) : srem2[F+2:0];
        root_q <= {root_q[F-1:0], sge};
      end
      vgrp_pkg::OP_SQRT_SAVE: begin
        if (cmd_i.sel == vgrp_pkg::SQ_B) b1_q <= root_q;
        else                             a1_q <= root_q;
      end
      vgrp_pkg::OP_MUL: begin
        case (cmd_i.sel)
          vgrp_pkg::MUL_KA2: ka_q <= msat;
          vgrp_pkg::MUL_KB1: b1_q <= msat;
          vgrp_pkg::MUL_KB2: kb_q <= msat;
          default:           acc_q <= msat;
        endcase
      end
      vgrp_pkg::OP_OUT: begin
        perm_a_q  <= bad_q ? '0 : ka_q;
        perm_b_q  <= bad_q ? '0 : kb_q;
        bad_out_q <= bad_q;
      end
      default: ;
    endcase
  end

  assign perm_a_o     = perm_a_q;
  assign perm_b_o     = perm_b_q;
  assign bad_config_o = bad_out_q;

endmodule

[hw/rtl/vgrp_ctrl.sv]
// Controller: microcoded sequencer that steps the datapath through one cell.
module vgrp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  vgrp_pkg::sts_t sts_i,
  output vgrp_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] REP_ONCE = 3'd0;  // issued once
  localparam logic [2:0] REP_DIV  = 3'd1;  // one per quotient bit
  localparam logic [2:0] REP_FRAC = 3'd2;  // one per fraction bit
  localparam logic [2:0] REP_SQRT = 3'd3;  // one per root bit
  localparam logic [2:0] REP_NORM = 3'd4;  // until normalized

  localparam logic [5:0] LAST_PC = 6'd36;

  typedef struct packed {
    vgrp_pkg::op_e                op;
    logic [vgrp_pkg::SEL_W-1:0]   sel;
    logic [2:0]                   rep;
  } uop_t;

  logic [1:0]                 state_q, state_d;
  logic [5:0]                 pc_q, pc_d;
  logic [vgrp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  uop_t                       uop;
  logic                       last;

  // microcode
  always_comb begin
    uop = '{vgrp_pkg::OP_NONE, '0, REP_ONCE};
    case (pc_q)
      6'd0:  uop = '{vgrp_pkg::OP_DIV_INIT,  vgrp_pkg::DIV_SE,   REP_ONCE};
      6'd1:  uop = '{vgrp_pkg::OP_DIV_STEP,  '0,                 REP_DIV};
      6'd2:  uop = '{vgrp_pkg::OP_DIV_SAVE,  vgrp_pkg::DIV_SE,   REP_ONCE};
      6'd3:  uop = '{vgrp_pkg::OP_DIV_INIT,  vgrp_pkg::DIV_M,    REP_ONCE};
      6'd4:  uop = '{vgrp_pkg::OP_DIV_STEP,  '0,                 REP_DIV};
      6'd5:  uop = '{vgrp_pkg::OP_DIV_SAVE,  vgrp_pkg::DIV_M,    REP_ONCE};
      6'd6:  uop = '{vgrp_pkg::OP_DIV_INIT,  vgrp_pkg::DIV_INVM, REP_ONCE};
      6'd7:  uop = '{vgrp_pkg::OP_DIV_STEP,  '0,                 REP_DIV};
      6'd8:  uop = '{vgrp_pkg::OP_DIV_SAVE,  vgrp_pkg::DIV_INVM, REP_ONCE};
      6'd9:  uop = '{vgrp_pkg::OP_LOG_INIT,  vgrp_pkg::LOG_SE,   REP_ONCE};
      6'd10: uop = '{vgrp_pkg::OP_LOG_NORM,  '0,                 REP_NORM};
      6'd11: uop = '{vgrp_pkg::OP_LOG_SQ,    '0,                 REP_FRAC};
      6'd12: uop = '{vgrp_pkg::OP_LOG_SAVE,  '0,                 REP_ONCE};
      6'd13: uop = '{vgrp_pkg::OP_EXP_INIT,  vgrp_pkg::EXA_INVM, REP_ONCE};
      6'd14: uop = '{vgrp_pkg::OP_EXP_STEP,  '0,                 REP_FRAC};
      6'd15: uop = '{vgrp_pkg::OP_EXP_SAVE,  vgrp_pkg::DST_T,    REP_ONCE};
      6'd16: uop = '{vgrp_pkg::OP_LOG_INIT,  vgrp_pkg::LOG_U,    REP_ONCE};
      6'd17: uop = '{vgrp_pkg::OP_LOG_NORM,  '0,                 REP_NORM};
      6'd18: uop = '{vgrp_pkg::OP_LOG_SQ,    '0,                 REP_FRAC};
      6'd19: uop = '{vgrp_pkg::OP_LOG_SAVE,  '0,                 REP_ONCE};
      6'd20: uop = '{vgrp_pkg::OP_EXP_INIT,  vgrp_pkg::EXA_M2,   REP_ONCE};
      6'd21: uop = '{vgrp_pkg::OP_EXP_STEP,  '0,                 REP_FRAC};
      6'd22: uop = '{vgrp_pkg::OP_EXP_SAVE,  vgrp_pkg::DST_A2,   REP_ONCE};
      6'd23: uop = '{vgrp_pkg::OP_EXP_INIT,  vgrp_pkg::EXA_M,    REP_ONCE};
      6'd24: uop = '{vgrp_pkg::OP_EXP_STEP,  '0,                 REP_FRAC};
      6'd25: uop = '{vgrp_pkg::OP_EXP_SAVE,  vgrp_pkg::DST_V,    REP_ONCE};
      6'd26: uop = '{vgrp_pkg::OP_SQRT_INIT, vgrp_pkg::SQ_A,     REP_ONCE};
      6'd27: uop = '{vgrp_pkg::OP_SQRT_STEP, '0,                 REP_SQRT};
      6'd28: uop = '{vgrp_pkg::OP_SQRT_SAVE, vgrp_pkg::SQ_A,     REP_ONCE};
      6'd29: uop = '{vgrp_pkg::OP_SQRT_INIT, vgrp_pkg::SQ_B,     REP_ONCE};
      6'd30: uop = '{vgrp_pkg::OP_SQRT_STEP, '0,                 REP_SQRT};
      6'd31: uop = '{vgrp_pkg::OP_SQRT_SAVE, vgrp_pkg::SQ_B,     REP_ONCE};
      6'd32: uop = '{vgrp_pkg::OP_MUL,       vgrp_pkg::MUL_KA1,  REP_ONCE};
      6'd33: uop = '{vgrp_pkg::OP_MUL,       vgrp_pkg::MUL_KA2,  REP_ONCE};
      6'd34: uop = '{vgrp_pkg::OP_MUL,       vgrp_pkg::MUL_W,    REP_ONCE};
      6'd35: uop = '{vgrp_pkg::OP_MUL,       vgrp_pkg::MUL_KB1,  REP_ONCE};
      6'd36: uop = '{vgrp_pkg::OP_MUL,       vgrp_pkg::MUL_KB2,  REP_ONCE};
      default: ;
    endcase
  end

  always_comb begin
    case (uop.rep)
      REP_DIV:  last = cnt_q == vgrp_pkg::CNT_W'(vgrp_pkg::DIV_W - 1);
      REP_FRAC: last = cnt_q == vgrp_pkg::CNT_W'(vgrp_pkg::FRAC - 1);
      REP_SQRT: last = cnt_q == vgrp_pkg::CNT_W'(vgrp_pkg::FRAC);
      REP_NORM: last = sts_i.norm_done;
      default:  last = 1'b1;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '{vgrp_pkg::OP_NONE, '0, cnt_q};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = vgrp_pkg::OP_LOAD;
          pc_d     = '0;
          cnt_d    = '0;
          // a bad denominator skips all arithmetic
          state_d  = sts_i.bad ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.op  = uop.op;
        cmd_o.sel = uop.sel;
        if (uop.rep == REP_NORM && sts_i.norm_done) cmd_o.op = vgrp_pkg::OP_NONE;
        if (last) begin
          cnt_d = '0;
          if (pc_q == LAST_PC) state_d = ST_FIN;
          else                 pc_d    = pc_q + 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = vgrp_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/van_genuchten_rel_permeability.sv]
// Top level of the van Genuchten-Mualem relative permeability block.
//
//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+---------------------------------
//  in      | in  | in_valid_i / in_ready_o   | sat_b_i
//  out     | out | out_valid_o / out_ready_i | perm_a_o, perm_b_o, bad_config_o
//  cfg     | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A result is valid once the shared restoring divider (three 33-step divisions),
// the log2 unit (one squaring per fraction bit plus one shift per leading zero,
// 0 to 16 shifts in each of the two log2 runs), three 16-step exp2 runs and
// two 17-step square roots have run after the accepting edge, all in sequence
// on one datapath. A bad denominator skips the arithmetic and goes from accept
// straight to the output state. A new word is accepted once the previous result
// sits in the output register, even if it is still stalled. Reset is
// asynchronous, active low, and needs no clearing pass.
`include "van_genuchten_rel_permeability_macros.svh"

module van_genuchten_rel_permeability (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vgrp_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [vgrp_pkg::N_W-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vgrp_pkg::FX_W-1:0]    sat_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vgrp_pkg::FX_W-1:0]    perm_a_o,
  output logic [vgrp_pkg::FX_W-1:0]    perm_b_o,
  output logic                         bad_config_o
);

  vgrp_pkg::cmd_t cmd;
  vgrp_pkg::sts_t sts;

  // sequencer: accepts a word, walks the microcode, hands off to the output
  vgrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic, config registers and the output register
  vgrp_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sat_b_i      (sat_b_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .perm_a_o     (perm_a_o),
    .perm_b_o     (perm_b_o),
    .bad_config_o (bad_config_o)
  );

  // one word at a time: ready drops right after an accept
  `VGRP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready held after accept")
  // a bad denominator always carries zero permeabilities
  `VGRP_ASSERT(a_bad_zero, !(out_valid_o && bad_config_o) || (perm_a_o == '0 && perm_b_o == '0), "bad word not zero")
  // results never exceed one
  `VGRP_ASSERT(a_range, !out_valid_o || (perm_a_o <= vgrp_pkg::ONE && perm_b_o <= vgrp_pkg::ONE), "result above one")

endmodule
